// ===== rtl/kdt_pkg.sv =====
// Shared types, widths and codes for the keyed device table.
// No dependencies; imported by every module of the block.
package kdt_pkg;

  localparam int MAX_ENTRIES  = 16;
  localparam int PAYLOAD_BITS = 64;

  localparam int KEY_W     = 48;
  localparam int OP_W      = 2;
  localparam int DATA_IN_W = 64;
  localparam int FIDX_W    = 4;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;

  localparam int IN_FIELDS_W  = OP_W + KEY_W + DATA_IN_W + FIDX_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ST_W + FIDX_W + KEY_W + DATA_IN_W + CNT_OUT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int IN_OP_LSB   = 0;
  localparam int IN_KEY_LSB  = IN_OP_LSB + OP_W;
  localparam int IN_DATA_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_IDX_LSB  = IN_DATA_LSB + DATA_IN_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     op;
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [FIDX_W-1:0]       idx;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [IDX_W-1:0]        pos;
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_W-1:0]        count;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } mem_wr_t;

endpackage

// ===== rtl/kdt_store.sv =====
// Entry storage: one write port, one read port with registered read data.
// Depends on kdt_pkg.
module kdt_store (
  input  logic                      clk,
  input  kdt_pkg::mem_wr_t          wr,
  input  logic [kdt_pkg::IDX_W-1:0] rd_addr,
  output kdt_pkg::entry_t           rd_entry
);
  import kdt_pkg::*;

  entry_t mem_r [MAX_ENTRIES];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.entry;
    end
    rd_entry_r <= mem_r[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

// ===== rtl/kdt_ctrl.sv =====
// Sequencer: scans the table one entry a cycle through a single key
// comparator, then updates, appends or compacts. Depends on kdt_pkg.
module kdt_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  input  kdt_pkg::req_t             req,
  output logic                      req_ready,
  output logic [kdt_pkg::IDX_W-1:0] rd_addr,
  input  kdt_pkg::entry_t           rd_entry,
  output kdt_pkg::mem_wr_t          wr,
  output logic                      res_valid,
  output kdt_pkg::res_t             res,
  input  logic                      res_ready
);
  import kdt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FETCH = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  res_t             res_r, res_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic             match_w;
  logic             idx_ok_w;

  assign match_w  = pend_r && (req_r.op == OP_READ || rd_entry.key == req_r.key);
  assign idx_ok_w = int'(req_r.idx) < int'(count_r);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = pidx_r;
    rd_addr   = scan_r[IDX_W-1:0];
    wr        = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt   = req;
          scan_nxt  = '0;
          state_nxt = (req.op == OP_READ) ? S_FETCH : S_SCAN;
        end
      end

      S_FETCH: begin
        rd_addr = IDX_W'(req_r.idx);
        if (idx_ok_w) begin
          pend_nxt  = 1'b1;
          pidx_nxt  = IDX_W'(req_r.idx);
          scan_nxt  = count_r;
          state_nxt = S_SCAN;
        end else begin
          res_nxt        = '0;
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end

      S_SCAN: begin
        if (match_w) begin
          res_nxt.status  = ST_DONE;
          res_nxt.pos     = pidx_r;
          res_nxt.key     = rd_entry.key;
          res_nxt.payload = rd_entry.payload;
          state_nxt       = S_DONE;
          case (req_r.op)
            OP_ADD: begin
              wr.en            = 1'b1;
              wr.addr          = pidx_r;
              wr.entry.key     = req_r.key;
              wr.entry.payload = req_r.payload;
              res_nxt.payload  = req_r.payload;
            end
            OP_REMOVE: begin
              scan_nxt  = CNT_W'(pidx_r) + CNT_W'(1);
              state_nxt = S_SHIFT;
            end
            default: ;
          endcase
        end else if (!pend_r && scan_r >= count_r) begin
          res_nxt        = '0;
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
          if (req_r.op == OP_ADD) begin
            if (count_r < MAX_CNT) begin
              wr.en            = 1'b1;
              wr.addr          = count_r[IDX_W-1:0];
              wr.entry.key     = req_r.key;
              wr.entry.payload = req_r.payload;
              count_nxt        = count_r + CNT_W'(1);
              res_nxt.status   = ST_DONE;
              res_nxt.pos      = count_r[IDX_W-1:0];
              res_nxt.key      = req_r.key;
              res_nxt.payload  = req_r.payload;
            end else begin
              res_nxt.status = ST_FULL;
            end
          end
        end else if (scan_r < count_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[IDX_W-1:0];
          scan_nxt = scan_r + CNT_W'(1);
        end
      end

      S_SHIFT: begin
        if (pend_r) begin
          wr.en    = 1'b1;
          wr.addr  = pidx_r - IDX_W'(1);
          wr.entry = rd_entry;
        end
        if (scan_r < count_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[IDX_W-1:0];
          scan_nxt = scan_r + CNT_W'(1);
        end else if (!pend_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    res_nxt.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    scan_r <= scan_nxt;
    pidx_r <= pidx_nxt;
  end

  assign res = res_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1) ||
               count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_SCAN || state_r == S_SHIFT))
    else $error("table write outside scan or shift");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (int'(pidx_r) < int'(count_r)))
    else $error("read issued at or above the entry count");

  a_done_ret: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_ready) |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after handoff");

endmodule

// ===== rtl/keyed_device_table.sv =====
// Keyed device table top level: stream ports, output register, sequencer
// and entry store. Depends on kdt_pkg, kdt_store and kdt_ctrl.
//
//   channel | dir | tdata bits | handshake
//   in_     | in  | 120        | in_tvalid / in_tready
//   out_    | out | 128        | out_tvalid / out_tready
//
// Add, search and remove scan the stored entries in order through the one read port of the
// entry store and a single key comparator, stopping at a hit; a remove that hits then shifts
// the later entries down one place. Read fetches the entry at entry_index, or not found past the count.
// rst_n clears the count; stored entries keep old contents. A new item is taken while a
// result waits in the output register; a second result holds the sequencer until drained.
module keyed_device_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // operation, device_address, entry_data, entry_index
  input  logic [kdt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, found_index, result_address, result_data, entry_count
  output logic [kdt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kdt_pkg::*;

  req_t             req;
  res_t             res;
  res_t             out_r;
  logic             out_valid_r;
  logic             res_valid;
  logic             res_ready;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  mem_wr_t          wr;

  assign req.op      = op_t'(in_tdata[IN_OP_LSB +: OP_W]);
  assign req.key     = in_tdata[IN_KEY_LSB +: KEY_W];
  assign req.payload = in_tdata[IN_DATA_LSB +: PAYLOAD_BITS];
  assign req.idx     = in_tdata[IN_IDX_LSB +: FIDX_W];

  kdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry),
    .wr        (wr),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  kdt_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}},
                       CNT_OUT_W'(out_r.count),
                       DATA_IN_W'(out_r.payload),
                       out_r.key,
                       FIDX_W'(out_r.pos),
                       out_r.status};

endmodule
